FILE: rtl/wrs_pkg.sv
// Shared constants, widths and the result record for the water ripple stencil.
// Used by wrs_lane, wrs_merge and the top level; depends on nothing.
package wrs_pkg;

  localparam int LANES         = 4;
  localparam int PX_W          = 8;
  localparam int SHADE_W       = 5;
  localparam int WORD_W        = LANES * PX_W;
  localparam int MAX_ROW_WORDS = 128;
  localparam int COL_W         = $clog2(MAX_ROW_WORDS);
  localparam int MIN_ROWS      = 3;
  localparam int MAX_ROWS      = 1024;
  localparam int ROW_W         = 10;
  localparam int RW_W          = 8;
  localparam int FR_W          = 11;
  localparam int RW_RESET      = 80;
  localparam int FR_RESET      = 200;
  localparam int CMP_W         = (RW_W > COL_W + 1) ? RW_W : COL_W + 1;

  localparam int IN_TDATA_W    = 2 * WORD_W;
  localparam int IN_TUSER_W    = 1;
  localparam int OUT_FIELDS_W  = LANES * (PX_W + SHADE_W);
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WORDS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 8'd1;

  typedef logic [PX_W-1:0] px_t;

  typedef struct packed {
    logic                          frame_last;
    logic [LANES-1:0][SHADE_W-1:0] shade;
    logic [LANES-1:0][PX_W-1:0]    new_h;
  } result_t;

endpackage

FILE: rtl/wrs_ram.sv
// Line buffer memory with one write port and two registered read ports.
// Reads at the address being written return the new data. No package use.
module wrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= (we && waddr == raddr_a) ? wdata : mem_r[raddr_a];
    rdata_b_r <= (we && waddr == raddr_b) ? wdata : mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

FILE: rtl/wrs_lane.sv
// One pixel of the stencil: neighbor sum, difference against the older height, magnitude.
// Depends on wrs_pkg for pixel widths.
module wrs_lane (
  input  wrs_pkg::px_t                left_px,
  input  wrs_pkg::px_t                right_px,
  input  wrs_pkg::px_t                up_px,
  input  wrs_pkg::px_t                down_px,
  input  wrs_pkg::px_t                old_px,
  output wrs_pkg::px_t                new_h,
  output logic [wrs_pkg::SHADE_W-1:0] shade
);

  logic [wrs_pkg::PX_W+1:0] sum;
  logic [wrs_pkg::PX_W-2:0] half;
  logic [wrs_pkg::PX_W-1:0] diff;
  logic [wrs_pkg::PX_W-1:0] mag;

  always_comb begin
    sum  = {2'b00, left_px} + {2'b00, right_px} + {2'b00, up_px} + {2'b00, down_px};
    half = sum[wrs_pkg::PX_W-1:1];
    diff = {1'b0, half} - old_px;
    mag  = diff[wrs_pkg::PX_W-1] ? (~diff + 1'b1) : diff;
  end

  assign new_h = mag;
  assign shade = mag[wrs_pkg::SHADE_W:1];

endmodule

FILE: rtl/wrs_merge.sv
// Collects the lane results into one item and holds it in an output register with a skid stage.
// Depends on wrs_pkg for the result record and stream widths.
module wrs_merge (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           push_valid,
  input  logic [wrs_pkg::LANES-1:0][wrs_pkg::PX_W-1:0]    lane_new_h,
  input  logic [wrs_pkg::LANES-1:0][wrs_pkg::SHADE_W-1:0] lane_shade,
  input  logic                                           lane_last,
  output logic                                           push_ready,
  output logic                                           out_tvalid,
  input  logic                                           out_tready,
  // Fields from bit 0: new_h0..new_h3, shade0..shade3, zero padding.
  output logic [wrs_pkg::OUT_TDATA_W-1:0]                 out_tdata,
  output logic                                           out_tlast
);

  wrs_pkg::result_t push_res;
  wrs_pkg::result_t out_r;
  wrs_pkg::result_t skid_r;
  logic             out_v_r;
  logic             skid_v_r;

  always_comb begin
    push_res.new_h      = lane_new_h;
    push_res.shade      = lane_shade;
    push_res.frame_last = lane_last;
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_r <= skid_v_r ? skid_r : push_res;
    end
    if (out_v_r && !out_tready && push_valid) begin
      skid_r <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      out_v_r  <= skid_v_r || push_valid;
      skid_v_r <= 1'b0;
    end else if (push_valid) begin
      skid_v_r <= 1'b1;
    end
  end

  assign push_ready = !skid_v_r;
  assign out_tvalid = out_v_r;
  assign out_tlast  = out_r.frame_last;
  assign out_tdata  = wrs_pkg::OUT_TDATA_W'({out_r.shade, out_r.new_h});

endmodule

FILE: rtl/water_ripple_stencil.sv
// Top level of the water ripple stencil: position tracking, line buffers, lanes and output.
// Depends on wrs_pkg, wrs_ram, wrs_lane and wrs_merge.
//
// The block takes the current height frame in raster order, one four-pixel word per item
// on the in_ channel, with the older frame's word at the same place. in_tuser marks the
// first word of a frame. For every word of rows 2 to H-1 it returns, on the out_ channel,
// the new heights and shades of the word one row above; out_tlast marks the last result
// of a frame. Rows 0 and 1 give no results.
// Registers on the cfg_ channel: index 0 sets the width in words, index 1 the height in
// rows. Write them only while no item is in flight.
// Throughput is one item per cycle; the line buffers are read one word ahead through
// registered read ports so that no cycle is lost. Results are registered in the output
// stage. in_tready drops for one cycle after reset and after every register write (the
// prefetch is refreshed), and for one cycle when a frame start arrives in the middle of
// a row (the column is rewound first).
// While the receiver stalls, one more result is held in a skid stage; after that
// in_tready stays low until out_tready returns. Reset clears positions and the output
// stage and loads 80 words and 200 rows; buffer contents are undefined until written.
module water_ripple_stencil (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: cur_px0..cur_px3, old_px0..old_px3.
  input  logic [wrs_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Fields from bit 0: frame_start.
  input  logic [wrs_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0: new_h0..new_h3, shade0..shade3, zero padding.
  output logic [wrs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wrs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wrs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int COL_W  = wrs_pkg::COL_W;
  localparam int ROW_W  = wrs_pkg::ROW_W;
  localparam int WCNT_W = wrs_pkg::COL_W + 1;
  localparam int CMP_W  = wrs_pkg::CMP_W;
  localparam int FR_W   = wrs_pkg::FR_W;
  localparam int WORD_W = wrs_pkg::WORD_W;
  localparam int PX_W   = wrs_pkg::PX_W;
  localparam int LANES  = wrs_pkg::LANES;

  logic [wrs_pkg::RW_W-1:0] row_words_r;
  logic [FR_W-1:0]          frame_rows_r;
  logic                     cfg_hold_r;
  logic [COL_W-1:0]         col_r;
  logic [ROW_W-1:0]         row_r;
  logic [WORD_W-1:0]        win0_r;
  logic [WORD_W-1:0]        win1_r;

  logic [CMP_W-1:0]  rw_ext;
  logic [WCNT_W-1:0] w_eff;
  logic [COL_W-1:0]  w_m1;
  logic [FR_W-1:0]   h_eff;
  logic [ROW_W-1:0]  h_m1;
  logic [COL_W-1:0]  col_cl;
  logic              frame_start;
  logic              rewind;
  logic              acc;
  logic              merge_ready;
  logic [COL_W-1:0]  c;
  logic [ROW_W-1:0]  r;
  logic              last_col;
  logic [COL_W-1:0]  col_nxt;
  logic [ROW_W-1:0]  row_nxt;
  logic [COL_W-1:0]  pos_sel;
  logic [COL_W-1:0]  ra;
  logic              produce;
  logic              push;
  logic              frame_last;

  logic [WORD_W-1:0]   incoming;
  logic [WORD_W-1:0]   old_in;
  logic [2*WORD_W-1:0] co_rd_a;
  logic [2*WORD_W-1:0] co_rd_b;
  logic [WORD_W-1:0]   ab_rd_a;
  logic [WORD_W-1:0]   ab_rd_b;
  logic [WORD_W-1:0]   ctr_q;
  logic [WORD_W-1:0]   old_q;
  logic [WORD_W-1:0]   ctr_next_q;
  logic [WORD_W-1:0]   wnd1;

  logic [LANES-1:0][PX_W-1:0]             lane_new_h;
  logic [LANES-1:0][wrs_pkg::SHADE_W-1:0] lane_shade;

  // Effective frame size and position.
  always_comb begin
    rw_ext = CMP_W'(row_words_r);
    if (rw_ext == '0) begin
      w_eff = WCNT_W'(1);
    end else if (rw_ext > CMP_W'(wrs_pkg::MAX_ROW_WORDS)) begin
      w_eff = WCNT_W'(wrs_pkg::MAX_ROW_WORDS);
    end else begin
      w_eff = WCNT_W'(rw_ext);
    end
    w_m1 = COL_W'(w_eff - 1'b1);

    if (frame_rows_r < FR_W'(wrs_pkg::MIN_ROWS)) begin
      h_eff = FR_W'(wrs_pkg::MIN_ROWS);
    end else if (frame_rows_r > FR_W'(wrs_pkg::MAX_ROWS)) begin
      h_eff = FR_W'(wrs_pkg::MAX_ROWS);
    end else begin
      h_eff = frame_rows_r;
    end
    h_m1 = ROW_W'(h_eff - 1'b1);

    col_cl = ({1'b0, col_r} >= w_eff) ? w_m1 : col_r;
  end

  assign frame_start = in_tuser[0];
  assign rewind      = in_tvalid && frame_start && (col_r != '0);
  assign in_tready   = !cfg_hold_r && merge_ready && !(frame_start && (col_r != '0));
  assign acc         = in_tvalid && in_tready;

  always_comb begin
    c        = frame_start ? '0 : col_cl;
    r        = frame_start ? '0 : row_r;
    last_col = (c == w_m1);
    col_nxt  = last_col ? '0 : COL_W'(c + 1'b1);
    if (!last_col) begin
      row_nxt = r;
    end else if (r >= h_m1) begin
      row_nxt = '0;
    end else begin
      row_nxt = ROW_W'(r + 1'b1);
    end
    if (acc) begin
      pos_sel = col_nxt;
    end else if (rewind) begin
      pos_sel = '0;
    end else begin
      pos_sel = col_r;
    end
    ra         = ({1'b0, pos_sel} >= w_eff) ? w_m1 : pos_sel;
    produce    = (r >= ROW_W'(2)) && (r <= h_m1);
    frame_last = (r == h_m1) && last_col;
  end

  assign push = acc && produce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_words_r  <= wrs_pkg::RW_W'(wrs_pkg::RW_RESET);
      frame_rows_r <= FR_W'(wrs_pkg::FR_RESET);
      cfg_hold_r   <= 1'b1;
      col_r        <= '0;
      row_r        <= '0;
      win0_r       <= '0;
      win1_r       <= '0;
    end else begin
      cfg_hold_r <= cfg_valid;
      if (cfg_valid) begin
        unique case (cfg_index)
          wrs_pkg::CFG_ROW_WORDS:  row_words_r  <= cfg_data[wrs_pkg::RW_W-1:0];
          wrs_pkg::CFG_FRAME_ROWS: frame_rows_r <= cfg_data[FR_W-1:0];
          default: ;
        endcase
      end
      if (acc) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        win0_r <= ctr_q;
        if (c == '0) begin
          win1_r <= incoming;
        end
      end else if (rewind) begin
        col_r <= '0;
        row_r <= '0;
      end
    end
  end

  assign cfg_ready = 1'b1;

  assign incoming = in_tdata[WORD_W-1:0];
  assign old_in   = in_tdata[2*WORD_W-1:WORD_W];

  // Centre row and older row share one memory; port B looks one word ahead.
  wrs_ram #(
    .WIDTH (2 * WORD_W),
    .DEPTH (wrs_pkg::MAX_ROW_WORDS)
  ) u_centre_ram (
    .clk     (clk),
    .we      (acc),
    .waddr   (c),
    .wdata   ({old_in, incoming}),
    .raddr_a (ra),
    .raddr_b (COL_W'(ra + 1'b1)),
    .rdata_a (co_rd_a),
    .rdata_b (co_rd_b)
  );

  // Row above; port B holds the last word of that row for the left wrap.
  wrs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (wrs_pkg::MAX_ROW_WORDS)
  ) u_above_ram (
    .clk     (clk),
    .we      (acc),
    .waddr   (c),
    .wdata   (ctr_q),
    .raddr_a (ra),
    .raddr_b (w_m1),
    .rdata_a (ab_rd_a),
    .rdata_b (ab_rd_b)
  );

  assign ctr_q      = co_rd_a[WORD_W-1:0];
  assign old_q      = co_rd_a[2*WORD_W-1:WORD_W];
  assign ctr_next_q = co_rd_b[WORD_W-1:0];
  assign wnd1       = (c == '0) ? incoming : win1_r;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    wrs_pkg::px_t left_px;
    wrs_pkg::px_t right_px;

    if (i > 0) begin : g_left_in
      assign left_px = ctr_q[(i-1)*PX_W +: PX_W];
    end else begin : g_left_edge
      assign left_px = (c != '0) ? win0_r[(LANES-1)*PX_W +: PX_W]
                                 : ab_rd_b[(LANES-1)*PX_W +: PX_W];
    end

    if (i < LANES - 1) begin : g_right_in
      assign right_px = ctr_q[(i+1)*PX_W +: PX_W];
    end else begin : g_right_edge
      assign right_px = !last_col ? ctr_next_q[PX_W-1:0] : wnd1[PX_W-1:0];
    end

    wrs_lane u_lane (
      .left_px  (left_px),
      .right_px (right_px),
      .up_px    (ab_rd_a[i*PX_W +: PX_W]),
      .down_px  (incoming[i*PX_W +: PX_W]),
      .old_px   (old_q[i*PX_W +: PX_W]),
      .new_h    (lane_new_h[i]),
      .shade    (lane_shade[i])
    );
  end

  wrs_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push),
    .lane_new_h (lane_new_h),
    .lane_shade (lane_shade),
    .lane_last  (frame_last),
    .push_ready (merge_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_cfg_refresh: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> !(in_tvalid && in_tready))
    else $error("item accepted before the prefetch was refreshed after a register write");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && last_col) |=> (col_r == '0))
    else $error("column did not return to zero after the last word of a row");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_tvalid)
    else $error("result item lost between the lanes and the output stage");

endmodule
